>>> rtl/core/twed_pkg.sv
// twed_pkg: shared constants, event codes and the decoded-word record
// for the throttle word event decoder; no dependencies
package twed_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_W      = 3;
  localparam int WORD_W      = 16;
  localparam int LOCO_W      = 14;
  localparam int SPEED_W     = 10;
  localparam int FUNC_COUNT  = 29;
  localparam int FIDX_W      = 5;
  localparam int TURNOUT_W   = 11;
  localparam int OFFSET_W    = 16;
  localparam int ADDR_W      = 17;
  localparam int KIND_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int MASK_W      = 5;

  // event kinds
  localparam logic [KIND_W-1:0] EV_POWER   = 3'd0;
  localparam logic [KIND_W-1:0] EV_SPEED   = 3'd1;
  localparam logic [KIND_W-1:0] EV_DIR     = 3'd2;
  localparam logic [KIND_W-1:0] EV_FUNC    = 3'd3;
  localparam logic [KIND_W-1:0] EV_TURNOUT = 3'd4;

  // message types in bits 13:12
  localparam logic [1:0] MSG_SPEED = 2'd0;
  localparam logic [1:0] MSG_FN_LO = 2'd1;
  localparam logic [1:0] MSG_FN_HI = 2'd2;
  localparam logic [1:0] MSG_TURN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCO_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACC_OFFSET  = 2'd1;

  // special address field values
  localparam logic [LOCO_W-1:0] ADDR_POWER_OFF = 14'h0000;
  localparam logic [LOCO_W-1:0] ADDR_POWER_ON  = 14'h3FFE;

  // pending-event mask bit positions, lowest goes out first
  localparam int M_PWR = 0;
  localparam int M_SPD = 1;
  localparam int M_DIR = 2;
  localparam int M_FN  = 3;
  localparam int M_TO  = 4;

  // one decoded word, as it travels from the front to the back
  typedef struct packed {
    logic [MASK_W-1:0]    mask;
    logic                 pwr_val;
    logic [SPEED_W-1:0]   speed;
    logic                 dir;
    logic [FIDX_W-1:0]    fn_idx;
    logic                 fn_val;
    logic [TURNOUT_W-1:0] to_num;
    logic                 to_val;
    logic [LOCO_W-1:0]    loco;
  } cmd_t;

  function automatic logic [SLOT_IDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
    return SLOT_IDX_W'(s);
  endfunction

endpackage

>>> rtl/core/twed_front.sv
// twed_front: checks, classifies and applies throttle words to the slot store
// depends on twed_pkg
module twed_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [twed_pkg::SLOT_W-1:0]  slot,
  input  logic [twed_pkg::WORD_W-1:0]  data_word,
  output logic                         push,
  output twed_pkg::cmd_t               cmd
);

  logic [twed_pkg::LOCO_W-1:0]     loco_store  [twed_pkg::SLOT_COUNT];
  logic [twed_pkg::SPEED_W-1:0]    speed_store [twed_pkg::SLOT_COUNT];
  logic                            dir_store   [twed_pkg::SLOT_COUNT];
  logic [twed_pkg::FUNC_COUNT-1:0] func_store  [twed_pkg::SLOT_COUNT];

  logic [twed_pkg::SLOT_IDX_W-1:0] idx;
  logic                            word_ok;
  logic [twed_pkg::LOCO_W-1:0]     addr_field;
  logic [1:0]                      msg;
  logic [twed_pkg::SPEED_W-1:0]    new_speed;
  logic                            new_dir;
  logic [twed_pkg::FUNC_COUNT-1:0] old_func;
  logic [twed_pkg::FUNC_COUNT-1:0] new_func;
  logic [twed_pkg::FUNC_COUNT-1:0] diff;
  logic [twed_pkg::FUNC_COUNT-1:0] low_bit;
  logic [twed_pkg::FIDX_W-1:0]     low_idx;
  logic                            is_addr;
  logic                            write_loco;
  logic                            write_speed;
  logic                            write_func;

  assign idx        = twed_pkg::slot_idx(slot);
  assign word_ok    = (32'(slot) < 32'(twed_pkg::SLOT_COUNT)) &&
                      ((^data_word[14:0]) == data_word[15]);
  assign addr_field = data_word[13:0];
  assign msg        = data_word[13:12];
  assign is_addr    = data_word[14];
  assign new_speed  = {data_word[5:0], 4'b0000};
  assign new_dir    = data_word[6];
  assign old_func   = func_store[idx];

  always_comb begin
    case (msg)
      twed_pkg::MSG_SPEED: new_func = {old_func[28:5], data_word[11:7]};
      twed_pkg::MSG_FN_LO: new_func = {old_func[28:17], data_word[11:0], old_func[4:0]};
      twed_pkg::MSG_FN_HI: new_func = {data_word[11:0], old_func[16:0]};
      default:             new_func = old_func;
    endcase
  end

  // isolate lowest changed function, then encode its position
  assign diff    = old_func ^ new_func;
  assign low_bit = diff & (~diff + twed_pkg::FUNC_COUNT'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < twed_pkg::FUNC_COUNT; i++) begin
      if (low_bit[i]) low_idx = low_idx | twed_pkg::FIDX_W'(i);
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.loco    = loco_store[idx];
    cmd.pwr_val = (addr_field == twed_pkg::ADDR_POWER_ON);
    cmd.speed   = new_speed;
    cmd.dir     = new_dir;
    cmd.fn_idx  = low_idx;
    cmd.fn_val  = (|(new_func & low_bit));
    cmd.to_num  = data_word[10:0];
    cmd.to_val  = data_word[11];
    write_loco  = 1'b0;
    write_speed = 1'b0;
    write_func  = 1'b0;
    if (is_addr) begin
      if (addr_field == twed_pkg::ADDR_POWER_OFF || addr_field == twed_pkg::ADDR_POWER_ON) begin
        cmd.mask[twed_pkg::M_PWR] = 1'b1;
      end else begin
        write_loco = 1'b1;
      end
    end else begin
      case (msg)
        twed_pkg::MSG_SPEED: begin
          write_speed = 1'b1;
          write_func  = 1'b1;
          cmd.mask[twed_pkg::M_SPD] = (speed_store[idx] != new_speed);
          cmd.mask[twed_pkg::M_DIR] = (dir_store[idx] != new_dir);
          cmd.mask[twed_pkg::M_FN]  = (diff != '0);
        end
        twed_pkg::MSG_FN_LO, twed_pkg::MSG_FN_HI: begin
          write_func = 1'b1;
          cmd.mask[twed_pkg::M_FN] = (diff != '0);
        end
        default: begin
          cmd.mask[twed_pkg::M_TO] = (data_word[10:0] != '0);
        end
      endcase
    end
  end

  // words that change nothing visible leave no entry in the queue
  assign push = accept && word_ok && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < twed_pkg::SLOT_COUNT; i++) begin
        loco_store[i]  <= '0;
        speed_store[i] <= '0;
        dir_store[i]   <= 1'b0;
        func_store[i]  <= '0;
      end
    end else if (accept && word_ok) begin
      if (write_loco) loco_store[idx] <= addr_field;
      if (write_speed) begin
        speed_store[idx] <= new_speed;
        dir_store[idx]   <= new_dir;
      end
      if (write_func) func_store[idx] <= new_func;
    end
  end

endmodule

>>> rtl/core/twed_fifo.sv
// twed_fifo: short queue of decoded words between front and back
// depends on twed_pkg
module twed_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  twed_pkg::cmd_t push_data,
  input  logic           pop,
  output twed_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  twed_pkg::cmd_t                  entries [twed_pkg::FIFO_DEPTH];
  logic [twed_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [twed_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [twed_pkg::FIFO_CNT_W-1:0] count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == twed_pkg::FIFO_CNT_W'(twed_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + twed_pkg::FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + twed_pkg::FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + twed_pkg::FIFO_CNT_W'(1);
        2'b01:   count <= count - twed_pkg::FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/twed_back.sv
// twed_back: expands decoded words into events, one per cycle while the
// receiver is ready, into the output register; depends on twed_pkg
module twed_back (
  input  logic                          clk,
  input  logic                          rst,
  input  twed_pkg::cmd_t                head,
  input  logic                          empty,
  output logic                          pop,
  input  logic [twed_pkg::OFFSET_W-1:0] loco_offset,
  input  logic [twed_pkg::OFFSET_W-1:0] acc_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [twed_pkg::KIND_W-1:0]   event_kind,
  output logic [twed_pkg::ADDR_W-1:0]   target_address,
  output logic [twed_pkg::SPEED_W-1:0]  event_value,
  output logic [twed_pkg::FIDX_W-1:0]   function_index,
  output logic                          last_event
);

  twed_pkg::cmd_t                cur;
  twed_pkg::cmd_t                sel;
  logic [twed_pkg::MASK_W-1:0]   low;
  logic [twed_pkg::MASK_W-1:0]   rest;
  logic                          use_cur;
  logic                          have;
  logic                          can_load;
  logic                          step;
  logic [twed_pkg::KIND_W-1:0]   kind_next;
  logic [twed_pkg::ADDR_W-1:0]   addr_next;
  logic [twed_pkg::SPEED_W-1:0]  value_next;
  logic [twed_pkg::FIDX_W-1:0]   fidx_next;
  logic [twed_pkg::ADDR_W-1:0]   loco_addr;

  assign use_cur  = (cur.mask != '0);
  assign have     = use_cur || !empty;
  assign can_load = !out_valid || out_ready;
  assign step     = have && can_load;
  assign pop      = step && !use_cur;
  assign sel      = use_cur ? cur : head;
  assign low      = sel.mask & (~sel.mask + twed_pkg::MASK_W'(1));
  assign rest     = sel.mask & ~low;
  assign loco_addr = twed_pkg::ADDR_W'(loco_offset) + twed_pkg::ADDR_W'(sel.loco);

  always_comb begin
    kind_next  = twed_pkg::EV_POWER;
    addr_next  = '0;
    value_next = twed_pkg::SPEED_W'(sel.pwr_val);
    fidx_next  = '0;
    if (low[twed_pkg::M_SPD]) begin
      kind_next  = twed_pkg::EV_SPEED;
      addr_next  = loco_addr;
      value_next = sel.speed;
    end else if (low[twed_pkg::M_DIR]) begin
      kind_next  = twed_pkg::EV_DIR;
      addr_next  = loco_addr;
      value_next = sel.dir ? twed_pkg::SPEED_W'(2) : twed_pkg::SPEED_W'(1);
    end else if (low[twed_pkg::M_FN]) begin
      kind_next  = twed_pkg::EV_FUNC;
      addr_next  = loco_addr;
      value_next = twed_pkg::SPEED_W'(sel.fn_val);
      fidx_next  = sel.fn_idx;
    end else if (low[twed_pkg::M_TO]) begin
      kind_next  = twed_pkg::EV_TURNOUT;
      addr_next  = twed_pkg::ADDR_W'(acc_offset) + twed_pkg::ADDR_W'(sel.to_num);
      value_next = twed_pkg::SPEED_W'(sel.to_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur.mask  <= '0;
    end else if (step) begin
      out_valid   <= 1'b1;
      cur.mask    <= rest;
      cur.pwr_val <= sel.pwr_val;
      cur.speed   <= sel.speed;
      cur.dir     <= sel.dir;
      cur.fn_idx  <= sel.fn_idx;
      cur.fn_val  <= sel.fn_val;
      cur.to_num  <= sel.to_num;
      cur.to_val  <= sel.to_val;
      cur.loco    <= sel.loco;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_kind     <= kind_next;
      target_address <= addr_next;
      event_value    <= value_next;
      function_index <= fidx_next;
      last_event     <= (rest == '0);
    end
  end

endmodule

>>> rtl/core/throttle_word_event_decoder.sv
// throttle_word_event_decoder: top level, offset registers plus front, queue
// and back; depends on twed_pkg, twed_front, twed_fifo, twed_back
//
// usage:
//   input channel (in_valid/in_ready): slot and 16-bit throttle word. a word
//   with bad parity or an unknown slot is dropped, as is any word that
//   changes nothing visible.
//   output channel (out_valid/out_ready): one event per transaction; a word
//   gives up to three (speed, direction, lowest changed function), or one
//   power or turnout event. last_event marks the final one of a word.
//   config channel (cfg_valid/cfg_ready): always ready; index 0 is the
//   locomotive address offset, index 1 the accessory offset, other indexes
//   are ignored. write only while the block is idle.
// path: the first event of a word is written into a queue entry and passes
// from there into the output register.
// throughput: the back emits one event per cycle while the receiver is ready,
// and a word gives one to three events; the front takes a word every cycle while the
// four-entry queue has room, so in_ready drops only when the queue is full.
// reset: clears the per-slot store (address, speed, direction, functions),
// both offsets, the queue and the valid flag of the output register.
// a stalled receiver holds the event in the output register; the queue then
// fills and the input side stalls on its own.
module throttle_word_event_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [twed_pkg::SLOT_W-1:0]      slot,
  input  logic [twed_pkg::WORD_W-1:0]      data_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [twed_pkg::KIND_W-1:0]      event_kind,
  output logic [twed_pkg::ADDR_W-1:0]      target_address,
  output logic [twed_pkg::SPEED_W-1:0]     event_value,
  output logic [twed_pkg::FIDX_W-1:0]      function_index,
  output logic                             last_event,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twed_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [twed_pkg::OFFSET_W-1:0]    cfg_data
);

  logic [twed_pkg::OFFSET_W-1:0] loco_address_offset;
  logic [twed_pkg::OFFSET_W-1:0] accessory_address_offset;

  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  twed_pkg::cmd_t push_cmd;
  twed_pkg::cmd_t head_cmd;

  // config writes land directly in the offset registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loco_address_offset      <= '0;
      accessory_address_offset <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        twed_pkg::CFG_LOCO_OFFSET: loco_address_offset      <= cfg_data;
        twed_pkg::CFG_ACC_OFFSET:  accessory_address_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // front takes a word whenever the queue has a free entry
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  twed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .slot      (slot),
    .data_word (data_word),
    .push      (push),
    .cmd       (push_cmd)
  );

  twed_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .full      (full),
    .empty     (empty)
  );

  // back expands queued words into events, one per cycle while the receiver is ready
  twed_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head_cmd),
    .empty          (empty),
    .pop            (pop),
    .loco_offset    (loco_address_offset),
    .acc_offset     (accessory_address_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .target_address (target_address),
    .event_value    (event_value),
    .function_index (function_index),
    .last_event     (last_event)
  );

endmodule
